// File: rtl/core/imu_sensor_frame_parser_macros.svh
// Assertion macros shared by the IMU frame parser modules.
`ifndef IMU_SENSOR_FRAME_PARSER_MACROS_SVH
`define IMU_SENSOR_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ISFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ISFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/isfp_pkg.sv
// Types and constants shared by the IMU frame parser modules.
package isfp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [3:0] FRAME_LAST = 4'd10;

	localparam logic [7:0] TYPE_ACC   = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;
	localparam logic [7:0] TYPE_VOLT  = 8'h55;

	// Conversion class picked by the front end from the type byte.
	localparam logic [2:0] KIND_RAW   = 3'd0;
	localparam logic [2:0] KIND_ACC   = 3'd1;
	localparam logic [2:0] KIND_GYRO  = 3'd2;
	localparam logic [2:0] KIND_ANGLE = 3'd3;
	localparam logic [2:0] KIND_MAG   = 3'd4;
	localparam logic [2:0] KIND_VOLT  = 3'd5;

	// Configuration register indexes.
	localparam logic [0:0] REG_GZ_CLAMP   = 1'd0;
	localparam logic [0:0] REG_MISS_LIMIT = 1'd1;

	typedef struct packed {
		logic               evt;
		logic [7:0]         ftype;
		logic [2:0]         kind;
		logic signed [15:0] w0;
		logic signed [15:0] w1;
		logic signed [15:0] w2;
		logic               health;
		logic [15:0]        count;
	} job_t;

	typedef struct packed {
		logic               evt;
		logic [7:0]         ftype;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               health;
		logic [15:0]        count;
	} res_t;

endpackage

// File: rtl/core/isfp_fifo.sv
// Small register-based first-in first-out queue.
`include "imu_sensor_frame_parser_macros.svh"

module isfp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [W-1:0]                   wdata,
	input  logic                           pop,
	output logic [W-1:0]                   rdata,
	output logic                           full,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ISFP_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue written while full")
	`ISFP_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")

endmodule

// File: rtl/core/isfp_front.sv
// Front end: byte intake, frame assembly, poll timeout and frame classification.
`include "imu_sensor_frame_parser_macros.svh"

module isfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic                func,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          miss_limit,
	output logic                job_valid,
	output isfp_pkg::job_t      job
);

	logic [3:0]  cnt_q;
	logic [7:0]  bytes_q [1:7];
	logic [7:0]  miss_q;
	logic        health_q;
	logic [15:0] frames_q;

	logic accept;
	logic byte_in;
	logic frame_done;
	logic miss_hit;
	logic [2:0] kind;

	assign accept     = push && !full;
	assign byte_in    = accept && !func;
	assign frame_done = byte_in && (cnt_q == isfp_pkg::FRAME_LAST);
	assign miss_hit   = accept && func && (miss_q == miss_limit);
	assign job_valid  = frame_done || miss_hit;

	always_comb begin
		unique case (bytes_q[1])
			isfp_pkg::TYPE_ACC:   kind = isfp_pkg::KIND_ACC;
			isfp_pkg::TYPE_GYRO:  kind = isfp_pkg::KIND_GYRO;
			isfp_pkg::TYPE_ANGLE: kind = isfp_pkg::KIND_ANGLE;
			isfp_pkg::TYPE_MAG:   kind = isfp_pkg::KIND_MAG;
			isfp_pkg::TYPE_VOLT:  kind = isfp_pkg::KIND_VOLT;
			default:              kind = isfp_pkg::KIND_RAW;
		endcase
	end

	// A timeout carries zero words and type zero, so the raw path yields zeros.
	always_comb begin
		job.evt    = !frame_done;
		job.ftype  = frame_done ? bytes_q[1] : 8'h00;
		job.kind   = frame_done ? kind : isfp_pkg::KIND_RAW;
		job.w0     = frame_done ? $signed({bytes_q[3], bytes_q[2]}) : 16'sd0;
		job.w1     = frame_done ? $signed({bytes_q[5], bytes_q[4]}) : 16'sd0;
		job.w2     = frame_done ? $signed({bytes_q[7], bytes_q[6]}) : 16'sd0;
		job.health = frame_done;
		job.count  = frame_done ? frames_q + 16'd1 : frames_q;
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= 7; i++) begin
			if (byte_in && cnt_q == 4'(i)) begin
				bytes_q[i] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			miss_q   <= '0;
			health_q <= 1'b0;
			frames_q <= '0;
		end else begin
			if (byte_in) begin
				miss_q <= '0;
				if (cnt_q == '0) begin
					cnt_q <= (rx_byte == isfp_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
				end else if (frame_done) begin
					cnt_q    <= '0;
					health_q <= 1'b1;
					frames_q <= frames_q + 16'd1;
				end else begin
					cnt_q <= cnt_q + 4'd1;
				end
			end else if (accept) begin
				miss_q <= miss_q + 8'd1;
				if (miss_hit) begin
					health_q <= 1'b0;
				end
			end
		end
	end

	`ISFP_ASSERT_NEXT(a_frame_rewinds, frame_done, cnt_q == '0 && health_q,
		"byte counter did not restart after a frame")
	`ISFP_ASSERT_NEXT(a_timeout_drops_health, miss_hit, !health_q,
		"health still set after a timeout")

endmodule

// File: rtl/core/isfp_back.sv
// Back end: scales the payload words of known types to Q16.16 (other types pass unscaled) and applies the gyro z limit.
`include "imu_sensor_frame_parser_macros.svh"

module isfp_back #(
	parameter int OUT_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [26:0]                      gz_clamp,
	input  logic                             job_empty,
	input  isfp_pkg::job_t                   job,
	output logic                             job_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                             out_push,
	output isfp_pkg::res_t                   res
);

	localparam int CW = $clog2(OUT_DEPTH + 1);

	localparam logic signed [25:0] K_ACC   = 26'sd20566036;
	localparam logic signed [25:0] K_GYRO  = 26'sd4000;
	localparam logic signed [25:0] K_ANGLE = 26'sd360;
	localparam logic signed [25:0] K_MAG   = 26'sd65536;
	localparam logic signed [25:0] K_VOLT  = 26'sd3379;
	localparam logic signed [25:0] K_ONE   = 26'sd1;

	function automatic logic signed [25:0] scale_of(input logic [2:0] kind,
		input logic [1:0] lane);
		logic signed [25:0] k;
		unique case (kind)
			isfp_pkg::KIND_ACC:   k = K_ACC;
			isfp_pkg::KIND_GYRO:  k = K_GYRO;
			isfp_pkg::KIND_ANGLE: k = K_ANGLE;
			isfp_pkg::KIND_MAG:   k = K_MAG;
			isfp_pkg::KIND_VOLT:  k = (lane == 2'd0) ? K_VOLT : 26'sd0;
			default:              k = K_ONE;
		endcase
		return k;
	endfunction

	logic               valid_s1;
	logic signed [41:0] prod_s1 [3];
	logic [2:0]         kind_s1;
	logic               evt_s1;
	logic [7:0]         ftype_s1;
	logic               health_s1;
	logic [15:0]        count_s1;

	logic [CW:0]        in_flight;
	logic signed [41:0] shifted [3];
	logic signed [41:0] lim;
	logic               z_clip;

	// Credit check: everything in the multiply stage must find room downstream.
	assign in_flight = {1'b0, out_count} + (CW + 1)'(valid_s1);
	assign job_pop   = !job_empty && (in_flight < (CW + 1)'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (job_pop) begin
			prod_s1[0] <= 42'(job.w0) * 42'(scale_of(job.kind, 2'd0));
			prod_s1[1] <= 42'(job.w1) * 42'(scale_of(job.kind, 2'd1));
			prod_s1[2] <= 42'(job.w2) * 42'(scale_of(job.kind, 2'd2));
			kind_s1    <= job.kind;
			evt_s1     <= job.evt;
			ftype_s1   <= job.ftype;
			health_s1  <= job.health;
			count_s1   <= job.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= job_pop;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (kind_s1)
				isfp_pkg::KIND_ACC:  shifted[i] = prod_s1[i] >>> 16;
				isfp_pkg::KIND_VOLT: shifted[i] = prod_s1[i] >>> 6;
				default:             shifted[i] = prod_s1[i];
			endcase
		end
	end

	assign lim    = $signed({15'd0, gz_clamp});
	assign z_clip = (kind_s1 == isfp_pkg::KIND_GYRO)
		&& ((prod_s1[2] > lim) || (prod_s1[2] < -lim));

	always_comb begin
		res.evt    = evt_s1;
		res.ftype  = ftype_s1;
		res.x      = shifted[0][31:0];
		res.y      = shifted[1][31:0];
		res.z      = z_clip ? 32'sd0 : shifted[2][31:0];
		res.health = health_s1;
		res.count  = count_s1;
	end

	assign out_push = valid_s1;

	`ISFP_ASSERT_NOW(a_room_for_result, valid_s1, out_count < CW'(OUT_DEPTH),
		"result stage finished with no room in the output queue")

endmodule

// File: rtl/core/imu_sensor_frame_parser.sv
// Top level of the IMU serial frame parser: configuration registers and block wiring.
//
// Input channel: one transaction per received UART byte (func = 0) or per empty
// poll (func = 1); it is taken at a rising edge with push high and full low.
// The front end hunts for the 0x55 header, gathers 11-byte frames and, on the
// last byte, classifies the type byte; a run of empty polls that meets
// miss_limit raises a timeout. Each such event goes into a two-entry job queue.
// The back end multiplies the three words by a per-type constant in one
// registered stage, then shifts, applies the gyro z limit and writes the output
// queue. A result shows on the result ports while empty is low and leaves with
// pop. From the accepting edge a transaction is registered in the job queue,
// the single multiply stage and the output queue, where empty falls; one
// transaction per cycle is sustained while the receiver pops. If it stalls, the
// output and then the job queue fill; full rises only when both are full. Reset
// empties both queues, clears the byte count, miss count, health and frame
// count, and reloads the configuration defaults. Configuration writes are
// always taken (cfg_ready is high) and must occur only while the block is idle.
`include "imu_sensor_frame_parser_macros.svh"

module imu_sensor_frame_parser #(
	parameter int JOB_DEPTH = 2,
	parameter int OUT_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic               event_res,
	output logic [7:0]         frame_type,
	output logic signed [31:0] value_x,
	output logic signed [31:0] value_y,
	output logic signed [31:0] value_z,
	output logic               health_ok,
	output logic [15:0]        frame_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [26:0]        cfg_data
);

	localparam int JW = $bits(isfp_pkg::job_t);
	localparam int RW = $bits(isfp_pkg::res_t);

	// Configuration registers.
	logic [26:0] gz_clamp_q;
	logic [7:0]  miss_limit_q;

	logic                           job_valid;
	isfp_pkg::job_t                 job_new;
	logic [JW-1:0]                  job_rdata;
	isfp_pkg::job_t                 job_head;
	logic                           job_empty;
	logic                           job_pop;

	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic                           out_push;
	isfp_pkg::res_t                 res_new;
	logic [RW-1:0]                  out_rdata;
	isfp_pkg::res_t                 res_head;
	logic                           out_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gz_clamp_q   <= 27'd131072000;
			miss_limit_q <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				isfp_pkg::REG_GZ_CLAMP:   gz_clamp_q   <= cfg_data;
				isfp_pkg::REG_MISS_LIMIT: miss_limit_q <= cfg_data[7:0];
				default:                  miss_limit_q <= miss_limit_q;
			endcase
		end
	end

	isfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.rx_byte    (rx_byte),
		.miss_limit (miss_limit_q),
		.job_valid  (job_valid),
		.job        (job_new)
	);

	// The front end only produces a job on an accepted transaction, and
	// acceptance already requires room in this queue.
	isfp_fifo #(
		.W     (JW),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.wdata  (job_new),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.full   (full),
		.empty  (job_empty),
		.count  ()
	);

	assign job_head = isfp_pkg::job_t'(job_rdata);

	isfp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gz_clamp  (gz_clamp_q),
		.job_empty (job_empty),
		.job       (job_head),
		.job_pop   (job_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.res       (res_new)
	);

	// The back end reserves a slot before it starts a job, so this queue
	// never sees a write while full.
	isfp_fifo #(
		.W     (RW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_new),
		.pop    (out_pop),
		.rdata  (out_rdata),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

	assign out_pop  = pop && !empty;
	assign res_head = isfp_pkg::res_t'(out_rdata);

	assign event_res   = res_head.evt;
	assign frame_type  = res_head.ftype;
	assign value_x     = res_head.x;
	assign value_y     = res_head.y;
	assign value_z     = res_head.z;
	assign health_ok   = res_head.health;
	assign frame_count = res_head.count;

	`ISFP_ASSERT_NEXT(a_cfg_miss_limit, cfg_valid && cfg_index == isfp_pkg::REG_MISS_LIMIT,
		miss_limit_q == $past(cfg_data[7:0]), "miss limit write was lost")

endmodule

// File: bench/imu_sensor_frame_parser_tb.sv
// Self-checking testbench for the IMU serial frame parser: directed frames, then random traffic.
`timescale 1ns / 100ps

module imu_sensor_frame_parser_tb;

	// Meaning of the func input and of the event_res output.
	localparam logic FUNC_BYTE   = 1'b0;
	localparam logic FUNC_POLL   = 1'b1;
	localparam logic EVT_FRAME   = 1'b0;
	localparam logic EVT_TIMEOUT = 1'b1;

	// Frame geometry and the per-type scale factors of the conversion.
	localparam int     FRAME_LEN  = 11;
	localparam longint ACC_GAIN   = 20566036;
	localparam int     ACC_SHIFT  = 16;
	localparam longint GYRO_GAIN  = 4000;
	localparam longint ANGLE_GAIN = 360;
	localparam longint MAG_GAIN   = 65536;
	localparam longint VOLT_GAIN  = 3379;
	localparam int     VOLT_SHIFT = 6;

	// Register values after reset.
	localparam logic [26:0] GYRO_LIMIT_RESET = 27'd131072000;
	localparam logic [7:0]  MISS_LIMIT_RESET = 8'd10;

	// Run shape.
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 175;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_TAIL      = 20;
	localparam int HOLD_AFTER    = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 4000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               func = FUNC_BYTE;
	logic [7:0]         rx_byte = 8'h00;
	logic               empty;
	logic               pop = 1'b0;
	logic               event_res;
	logic [7:0]         frame_type;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	logic               health_ok;
	logic [15:0]        frame_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = isfp_pkg::REG_GZ_CLAMP;
	logic [26:0]        cfg_data = '0;

	imu_sensor_frame_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.event_res   (event_res),
		.frame_type  (frame_type),
		.value_x     (value_x),
		.value_y     (value_y),
		.value_z     (value_z),
		.health_ok   (health_ok),
		.frame_count (frame_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever begin
			#1 clk = ~clk;
		end
	end

	// One directed frame. The polls and the optional junk byte go out ahead of the header;
	// the trailing byte value fills the three bytes after the third word. Where typed is
	// set, the decoded values of the frame are given right here instead of being predicted.
	typedef struct {
		int unsigned        polls;
		bit                 junk_on;
		logic [7:0]         junk;
		logic [7:0]         ftype;
		logic [15:0]        w0;
		logic [15:0]        w1;
		logic [15:0]        w2;
		logic [7:0]         trail;
		bit                 typed;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        count;
	} frame_row_t;

	// The first row runs eleven polls from reset, so the eleventh meets the default miss
	// limit and reports a timeout. The third row sends ten polls, which must not time out
	// because the frame bytes before them cleared the miss count. Junk bytes exercise the
	// bad header path. Word extremes cover every conversion, and the gyro row puts z exactly
	// on the negative limit, which is kept.
	frame_row_t dir_rows [0:7] = '{
		'{11, 1'b1, 8'h00, isfp_pkg::TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000, 8'hFF,
			1'b1, 10282704, -10283018, 0, 16'd1},
		'{0, 1'b1, 8'hFF, isfp_pkg::TYPE_GYRO, 16'h7FFF, 16'h8000, 16'h8000, 8'h00,
			1'b1, 131068000, -131072000, -131072000, 16'd2},
		'{10, 1'b0, 8'h00, isfp_pkg::TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h0001, 8'hA5,
			1'b1, 11796120, -11796480, 360, 16'd3},
		'{0, 1'b0, 8'h00, isfp_pkg::TYPE_MAG, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h5A,
			1'b1, 2147418112, 32'sh8000_0000, -65536, 16'd4},
		'{0, 1'b0, 8'h00, isfp_pkg::TYPE_VOLT, 16'h7FFF, 16'h8000, 16'h1234, 8'h55,
			1'b1, 1729995, 0, 0, 16'd5},
		'{0, 1'b0, 8'h00, 8'h00, 16'h8000, 16'h7FFF, 16'hFFFF, 8'h3C,
			1'b1, -32768, 32767, -1, 16'd6},
		'{3, 1'b1, 8'h54, 8'hFF, 16'h1234, 16'hABCD, 16'h5555, 8'h0F,
			1'b0, 0, 0, 0, 16'd0},
		'{0, 1'b0, 8'h00, isfp_pkg::TYPE_VOLT, 16'h8000, 16'h7FFF, 16'h0000, 8'hC3,
			1'b1, -1730048, 0, 0, 16'd8}
	};

	// Shadow copy of the parser state and of its two registers.
	logic [7:0]  mdl_bytes [FRAME_LEN];
	int          mdl_count = 0;
	logic [7:0]  mdl_miss = '0;
	logic        mdl_health = 1'b0;
	logic [15:0] mdl_frames = '0;
	logic [26:0] mdl_gyro_lim = GYRO_LIMIT_RESET;
	logic [7:0]  mdl_miss_lim = MISS_LIMIT_RESET;

	// Reports that the block still owes, oldest first.
	isfp_pkg::res_t awaited_reports [$];

	int unsigned n_errors = 0;
	int unsigned results_seen = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          draining = 1'b0;

	// Advances the shadow state by one accepted transaction and yields the report, if any,
	// that the transaction produces.
	task automatic imu_decode(input logic f, input logic [7:0] b, output bit hit,
			output isfp_pkg::res_t rep);
		logic signed [15:0] w0;
		logic signed [15:0] w1;
		logic signed [15:0] w2;
		longint             x;
		longint             y;
		longint             z;
		longint             lim;
		hit = 1'b0;
		rep = '0;
		if (f == FUNC_POLL) begin
			// The miss count is compared before it is bumped, and it wraps at eight bits.
			if (mdl_miss == mdl_miss_lim) begin
				hit = 1'b1;
				mdl_health = 1'b0;
				rep.evt = EVT_TIMEOUT;
				rep.count = mdl_frames;
			end
			mdl_miss = mdl_miss + 8'd1;
			return;
		end
		mdl_miss = '0;
		if (mdl_count < FRAME_LEN)
			mdl_bytes[mdl_count] = b;
		mdl_count++;
		if (mdl_bytes[0] != isfp_pkg::HDR_BYTE) begin
			mdl_count = 0;
			return;
		end
		if (mdl_count < FRAME_LEN)
			return;
		mdl_count = 0;
		mdl_health = 1'b1;
		mdl_frames = mdl_frames + 16'd1;
		w0 = {mdl_bytes[3], mdl_bytes[2]};
		w1 = {mdl_bytes[5], mdl_bytes[4]};
		w2 = {mdl_bytes[7], mdl_bytes[6]};
		lim = longint'(mdl_gyro_lim);
		case (mdl_bytes[1])
			isfp_pkg::TYPE_ACC: begin
				x = (longint'(w0) * ACC_GAIN) >>> ACC_SHIFT;
				y = (longint'(w1) * ACC_GAIN) >>> ACC_SHIFT;
				z = (longint'(w2) * ACC_GAIN) >>> ACC_SHIFT;
			end
			isfp_pkg::TYPE_GYRO: begin
				x = longint'(w0) * GYRO_GAIN;
				y = longint'(w1) * GYRO_GAIN;
				z = longint'(w2) * GYRO_GAIN;
				// Only a value strictly outside the band is dropped.
				if (z > lim || z < -lim)
					z = 0;
			end
			isfp_pkg::TYPE_ANGLE: begin
				x = longint'(w0) * ANGLE_GAIN;
				y = longint'(w1) * ANGLE_GAIN;
				z = longint'(w2) * ANGLE_GAIN;
			end
			isfp_pkg::TYPE_MAG: begin
				x = longint'(w0) * MAG_GAIN;
				y = longint'(w1) * MAG_GAIN;
				z = longint'(w2) * MAG_GAIN;
			end
			isfp_pkg::TYPE_VOLT: begin
				x = (longint'(w0) * VOLT_GAIN) >>> VOLT_SHIFT;
				y = 0;
				z = 0;
			end
			default: begin
				x = longint'(w0);
				y = longint'(w1);
				z = longint'(w2);
			end
		endcase
		hit = 1'b1;
		rep.evt = EVT_FRAME;
		rep.ftype = mdl_bytes[1];
		rep.x = x[31:0];
		rep.y = y[31:0];
		rep.z = z[31:0];
		rep.health = mdl_health;
		rep.count = mdl_frames;
	endtask

	// Offers one transaction and waits until it is taken. The sender works in bursts: when
	// a burst runs out and gaps are enabled, push first drops for a random pause. When typed
	// is set, the given report is queued instead of the predicted one.
	task automatic send_item(input logic f, input logic [7:0] b, input bit typed = 1'b0,
			input isfp_pkg::res_t want = '0);
		bit             hit;
		isfp_pkg::res_t rep;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
		push <= 1'b1;
		func <= f;
		rx_byte <= b;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		items_sent++;
		imu_decode(f, b, hit, rep);
		if (typed)
			awaited_reports.push_back(want);
		else if (hit)
			awaited_reports.push_back(rep);
	endtask

	// Sends the first len bytes of a frame; a full frame has FRAME_LEN bytes.
	task automatic send_frame(input int len, input logic [7:0] ft, input logic [15:0] w0,
			input logic [15:0] w1, input logic [15:0] w2, input logic [7:0] t0,
			input logic [7:0] t1, input logic [7:0] t2, input bit typed = 1'b0,
			input isfp_pkg::res_t want = '0);
		logic [7:0] bytes [FRAME_LEN];
		bytes = '{isfp_pkg::HDR_BYTE, ft, w0[7:0], w0[15:8], w1[7:0], w1[15:8], w2[7:0],
			w2[15:8], t0, t1, t2};
		for (int i = 0; i < len; i++)
			send_item(FUNC_BYTE, bytes[i], typed && i == FRAME_LEN - 1, want);
	endtask

	// Waits until the block has nothing left to deliver, then lets it run dry.
	task automatic settle();
		push <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back. Valid stays high between the two transactions
	// and only drops after the second one.
	task automatic write_limits(input logic [26:0] gz, input logic [7:0] ml);
		for (int r = 0; r < 2; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? isfp_pkg::REG_GZ_CLAMP : isfp_pkg::REG_MISS_LIMIT;
			cfg_data <= (r == 0) ? gz : {19'd0, ml};
			forever begin
				@(posedge clk);
				if (cfg_ready)
					break;
			end
			if (r == 0)
				mdl_gyro_lim = gz;
			else
				mdl_miss_lim = ml;
		end
		cfg_valid <= 1'b0;
	endtask

	// Random word with the extremes and the sign boundary weighted up.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 6))
			0: return isfp_pkg::TYPE_ACC;
			1: return isfp_pkg::TYPE_GYRO;
			2: return isfp_pkg::TYPE_ANGLE;
			3: return isfp_pkg::TYPE_MAG;
			4: return isfp_pkg::TYPE_VOLT;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] exp_val,
			input logic signed [63:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			n_errors++;
		end
	endtask

	// Result side. Every accepted transaction is compared with the oldest awaited report.
	// Pop follows a pattern that changes mode at random intervals: always ready, ready
	// half of the time, or ready one cycle in five. Once, after a number of results, pop
	// stays low for a long stretch while the sender keeps going, so that both internal
	// queues fill and full rises. During the final drain pop stays high.
	initial begin : result_side
		isfp_pkg::res_t want;
		int unsigned    mode_left;
		int unsigned    pop_pct;
		int unsigned    hold_left;
		bit             held;
		mode_left = 0;
		pop_pct = 100;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				results_seen++;
				if (awaited_reports.size() == 0) begin
					$error("result transaction with no report awaited: type %0h count %0d",
						frame_type, frame_count);
					n_errors++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("event_res", want.evt, event_res);
					check_field("frame_type", want.ftype, frame_type);
					check_field("value_x", want.x, value_x);
					check_field("value_y", want.y, value_y);
					check_field("value_z", want.z, value_z);
					check_field("health_ok", want.health, health_ok);
					check_field("frame_count", want.count, frame_count);
				end
			end
			if (!held && results_seen == HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(16, 128);
				case ($urandom_range(0, 2))
					0: pop_pct = 100;
					1: pop_pct = 50;
					default: pop_pct = 20;
				endcase
			end else begin
				mode_left--;
			end
			if (draining) begin
				pop <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(1, 100) <= pop_pct);
			end
		end
	end

	// Watchdog: the run is lost if no transaction of any kind is taken for too long.
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL imu_sensor_frame_parser");
		$finish;
	end

	// Stimulus side.
	initial begin : stimulus
		isfp_pkg::res_t want;
		logic [26:0]    gz;
		logic [7:0]     ml;
		int unsigned    phase_end;
		int unsigned    run;
		for (int i = 0; i < FRAME_LEN; i++)
			mdl_bytes[i] = '0;

		// Reset is held from the start and released on a clock edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset values of the registers.
		foreach (dir_rows[i]) begin
			repeat (dir_rows[i].polls) send_item(FUNC_POLL, 8'($urandom));
			if (dir_rows[i].junk_on)
				send_item(FUNC_BYTE, dir_rows[i].junk);
			want = '0;
			want.evt = EVT_FRAME;
			want.ftype = dir_rows[i].ftype;
			want.x = dir_rows[i].x;
			want.y = dir_rows[i].y;
			want.z = dir_rows[i].z;
			want.health = 1'b1;
			want.count = dir_rows[i].count;
			send_frame(FRAME_LEN, dir_rows[i].ftype, dir_rows[i].w0, dir_rows[i].w1,
				dir_rows[i].w2, dir_rows[i].trail, dir_rows[i].trail, dir_rows[i].trail,
				dir_rows[i].typed, want);
		end

		// Random phases. Each one starts from an idle block with new register values; the
		// first three are the reset values and the two extremes. Odd phases run the
		// sender without gaps.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					gz = GYRO_LIMIT_RESET;
					ml = MISS_LIMIT_RESET;
				end
				1: begin
					gz = '0;
					ml = '0;
				end
				2: begin
					gz = '1;
					ml = '1;
				end
				3: begin
					gz = 27'($urandom);
					ml = 8'($urandom_range(0, 20));
				end
				4: begin
					gz = 27'($urandom_range(0, GYRO_LIMIT_RESET));
					ml = 8'd1;
				end
				5: begin
					gz = 27'd6553600;
					ml = 8'd3;
				end
				6: begin
					gz = 27'($urandom);
					ml = 8'($urandom_range(0, 40));
				end
				default: begin
					gz = 27'd4000;
					ml = 8'd2;
				end
			endcase
			write_limits(gz, ml);
			gaps_on = (ph % 2 == 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 19))
					// A run of empty polls around the miss limit. Now and then the run is long enough for
					// the eight-bit miss count to wrap, and under a small limit to time out again.
					0, 1: begin
						run = $urandom_range(1, int'(mdl_miss_lim) + 3);
						if ($urandom_range(0, 40) == 0)
							run = 260;
						repeat (run) send_item(FUNC_POLL, 8'($urandom));
					end
					// Line noise; a stray header byte starts a frame that absorbs what follows.
					2, 3: send_item(FUNC_BYTE, 8'($urandom));
					// A frame cut short, so the next header lands inside it.
					4: send_frame($urandom_range(1, FRAME_LEN - 1), pick_type(), pick_word(),
						pick_word(), pick_word(), 8'($urandom), 8'($urandom), 8'($urandom));
					// Well-formed frame with random content.
					default: send_frame(FRAME_LEN, pick_type(), pick_word(), pick_word(),
						pick_word(), 8'($urandom), 8'($urandom), 8'($urandom));
				endcase
			end
		end

		// Drain: everything still owed must arrive, and nothing more may follow.
		push <= 1'b0;
		draining = 1'b1;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (END_TAIL) @(posedge clk);
		if (n_errors == 0 && awaited_reports.size() == 0) begin
			$display("PASS imu_sensor_frame_parser");
		end else begin
			$display("FAIL imu_sensor_frame_parser");
		end
		$finish;
	end

endmodule
